/* design/ert_pkg.sv */
`default_nettype none

package ert_pkg;

    localparam int BEAT_W     = 31;
    localparam int LAST_W     = 32;
    localparam int CNT_W      = 5;
    localparam int STEPCFG_W  = 6;
    localparam int PITCH_W    = 7;
    localparam int VEL_W      = 7;
    localparam int CHAN_W     = 5;
    localparam int IDXOUT_W   = 5;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;

    localparam logic [CHAN_W-1:0] CHAN_MIN = 5'd1;
    localparam logic [CHAN_W-1:0] CHAN_MAX = 5'd16;

    // Register index, taken from paddr[4:2].
    typedef enum logic [2:0] {
        REG_STEP_COUNT  = 3'd0,
        REG_PULSE_COUNT = 3'd1,
        REG_PITCH       = 3'd2,
        REG_VELOCITY    = 3'd3,
        REG_CHANNEL     = 3'd4,
        REG_ENABLE      = 3'd5,
        REG_MUTE        = 3'd6
    } t_reg_idx;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MOD   = 6'b000010,
        S_MUL   = 6'b000100,
        S_PLOAD = 6'b001000,
        S_PMOD  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    typedef struct packed {
        logic load_beat;
        logic load_prod;
        logic div_step;
        logic mul;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic fresh;
        logic div_last;
        logic hit;
        logic out_free;
    } t_dp_stat;

    typedef struct packed {
        logic [STEPCFG_W-1:0] step_count;
        logic [STEPCFG_W-1:0] pulse_count;
        logic [PITCH_W-1:0]   pitch;
        logic [VEL_W-1:0]     velocity;
        logic [CHAN_W-1:0]    channel;
        logic                 enable;
        logic                 mute;
    } t_cfg;

endpackage

`default_nettype wire

/* design/ert_ctrl.sv */
`default_nettype none

module ert_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_stall,
    input  ert_pkg::t_dp_stat  i_stat,
    output ert_pkg::t_dp_cmd   o_cmd
);

    ert_pkg::t_state r_state;
    ert_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ert_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ert_pkg::S_IDLE: begin
                // A request that is disabled, muted or repeats the last beat ends here.
                if (i_valid && i_stat.fresh) begin
                    o_cmd.load_beat = 1'b1;
                    n_state         = ert_pkg::S_MOD;
                end
            end
            ert_pkg::S_MOD: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = ert_pkg::S_MUL;
                end
            end
            ert_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ert_pkg::S_PLOAD;
            end
            ert_pkg::S_PLOAD: begin
                o_cmd.load_prod = 1'b1;
                n_state         = ert_pkg::S_PMOD;
            end
            ert_pkg::S_PMOD: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = ert_pkg::S_OUT;
                end
            end
            ert_pkg::S_OUT: begin
                if (!i_stat.hit) begin
                    n_state = ert_pkg::S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ert_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ert_pkg::S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != ert_pkg::S_IDLE);

endmodule

`default_nettype wire

/* design/ert_dp.sv */
`default_nettype none

module ert_dp #(
    parameter int MAX_STEPS = 32
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire  [ert_pkg::BEAT_W-1:0]         i_beat_number,
    input  ert_pkg::t_cfg                      i_cfg,
    input  ert_pkg::t_dp_cmd                   i_cmd,
    output ert_pkg::t_dp_stat                  o_stat,
    input  wire                                i_stall,
    output logic                               o_valid,
    output logic [ert_pkg::CHAN_W-1:0]         o_note_channel,
    output logic [ert_pkg::PITCH_W-1:0]        o_note_pitch,
    output logic [ert_pkg::VEL_W-1:0]          o_note_velocity,
    output logic [ert_pkg::IDXOUT_W-1:0]       o_step_index
);

    localparam int STEP_W = $clog2(MAX_STEPS + 1);
    localparam int IDX_W  = ($clog2(MAX_STEPS) < 1) ? 1 : $clog2(MAX_STEPS);
    localparam int PROD_W = IDX_W + STEP_W;
    localparam int CMP_W  = (STEP_W > ert_pkg::STEPCFG_W) ? STEP_W + 1 : ert_pkg::STEPCFG_W + 1;

    logic [ert_pkg::LAST_W-1:0] r_last_beat;
    logic [STEP_W-1:0]          r_steps;
    logic [STEP_W-1:0]          r_pulses;
    logic [ert_pkg::BEAT_W-1:0] r_dvd;
    logic [STEP_W-1:0]          r_rem;
    logic [ert_pkg::CNT_W-1:0]  r_cnt;
    logic [IDX_W-1:0]           r_step;
    logic [PROD_W-1:0]          r_prod;
    logic                       r_out_valid;
    logic [ert_pkg::CHAN_W-1:0]   r_chan;
    logic [ert_pkg::PITCH_W-1:0]  r_pitch;
    logic [ert_pkg::VEL_W-1:0]    r_vel;
    logic [ert_pkg::IDXOUT_W-1:0] r_idx;

    logic [CMP_W-1:0]           sc_wide;
    logic [CMP_W-1:0]           pc_wide;
    logic [CMP_W-1:0]           steps_wide;
    logic [STEP_W-1:0]          steps_eff;
    logic [STEP_W-1:0]          pulses_eff;
    logic [STEP_W:0]            trial;
    logic [STEP_W-1:0]          rem_next;
    logic [ert_pkg::CHAN_W-1:0] chan_eff;
    logic [31:0]                step_ext;

    // Effective cycle length and pulse count, latched when a beat starts.
    always_comb begin
        sc_wide = CMP_W'(i_cfg.step_count);
        pc_wide = CMP_W'(i_cfg.pulse_count);
        if (sc_wide == '0) begin
            steps_wide = CMP_W'(1);
        end else if (sc_wide > CMP_W'(MAX_STEPS)) begin
            steps_wide = CMP_W'(MAX_STEPS);
        end else begin
            steps_wide = sc_wide;
        end
        steps_eff  = steps_wide[STEP_W-1:0];
        pulses_eff = (pc_wide > steps_wide) ? steps_eff : pc_wide[STEP_W-1:0];
    end

    // One restoring remainder step per cycle; the remainder stays below the divisor.
    always_comb begin
        trial = {r_rem, r_dvd[ert_pkg::BEAT_W-1]};
        if (trial >= {1'b0, r_steps}) begin
            rem_next = STEP_W'(trial - {1'b0, r_steps});
        end else begin
            rem_next = trial[STEP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_beat <= '1;
        end else if (i_cmd.load_beat) begin
            r_last_beat <= {1'b0, i_beat_number};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_beat) begin
            r_steps  <= steps_eff;
            r_pulses <= pulses_eff;
            r_dvd    <= i_beat_number;
            r_rem    <= '0;
            r_cnt    <= ert_pkg::CNT_W'(ert_pkg::BEAT_W);
        end else if (i_cmd.load_prod) begin
            // Left-align the product so that only its own bits are iterated.
            r_dvd    <= ert_pkg::BEAT_W'(r_prod) << (ert_pkg::BEAT_W - PROD_W);
            r_rem    <= '0;
            r_cnt    <= ert_pkg::CNT_W'(PROD_W);
        end else if (i_cmd.div_step) begin
            r_dvd    <= {r_dvd[ert_pkg::BEAT_W-2:0], 1'b0};
            r_rem    <= rem_next;
            r_cnt    <= r_cnt - 1'b1;
        end
        if (i_cmd.mul) begin
            r_step <= r_rem[IDX_W-1:0];
            r_prod <= PROD_W'(r_rem[IDX_W-1:0]) * PROD_W'(r_pulses);
        end
    end

    always_comb begin
        if (i_cfg.channel < ert_pkg::CHAN_MIN) begin
            chan_eff = ert_pkg::CHAN_MIN;
        end else if (i_cfg.channel > ert_pkg::CHAN_MAX) begin
            chan_eff = ert_pkg::CHAN_MAX;
        end else begin
            chan_eff = i_cfg.channel;
        end
        step_ext = 32'(r_step);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_chan  <= chan_eff;
            r_pitch <= i_cfg.pitch;
            r_vel   <= i_cfg.velocity;
            r_idx   <= step_ext[ert_pkg::IDXOUT_W-1:0];
        end
    end

    // A step hits when (step * pulses) mod steps is below pulses; step zero always hits.
    assign o_stat.fresh    = i_cfg.enable && !i_cfg.mute
                             && (r_last_beat != {1'b0, i_beat_number});
    assign o_stat.div_last = (r_cnt == ert_pkg::CNT_W'(1));
    assign o_stat.hit      = (r_step == '0) || (r_rem < r_pulses);
    assign o_stat.out_free = !r_out_valid || !i_stall;

    assign o_valid         = r_out_valid;
    assign o_note_channel  = r_chan;
    assign o_note_pitch    = r_pitch;
    assign o_note_velocity = r_vel;
    assign o_step_index    = r_idx;

endmodule

`default_nettype wire

/* design/euclidean_rhythm_trigger.sv */
`default_nettype none
// Channel   Direction  Handshake               Payload
// input     in         i_valid / o_stall       i_beat_number
// output    out        o_valid / i_stall       o_note_channel, o_note_pitch,
//                                              o_note_velocity, o_step_index
// config    in         APB psel/penable/pready paddr, pwdata, prdata
//
// A beat that produces work is paced by the shared one-bit-per-cycle remainder unit,
// which runs once on the beat and once on step * pulses. Disabled, muted or repeated
// beats end in the idle state without any work being done.
// Reset is synchronous and returns the registers to their defaults and last beat to none.
// A new request is taken while a finished note still waits at the output; a stalled
// output holds the block in its last state until the note is taken.

module euclidean_rhythm_trigger #(
    parameter int MAX_STEPS = 32
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_stall,
    input  wire  [ert_pkg::BEAT_W-1:0]         i_beat_number,
    output logic                               o_valid,
    input  wire                                i_stall,
    output logic [ert_pkg::CHAN_W-1:0]         o_note_channel,
    output logic [ert_pkg::PITCH_W-1:0]        o_note_pitch,
    output logic [ert_pkg::VEL_W-1:0]          o_note_velocity,
    output logic [ert_pkg::IDXOUT_W-1:0]       o_step_index,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [ert_pkg::ADDR_W-1:0]         paddr,
    input  wire  [ert_pkg::DATA_W-1:0]         pwdata,
    output logic [ert_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);

    ert_pkg::t_cfg     r_cfg;
    ert_pkg::t_dp_cmd  cmd;
    ert_pkg::t_dp_stat stat;
    ert_pkg::t_reg_idx reg_idx;
    logic              wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = ert_pkg::t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_count  <= 6'd13;
            r_cfg.pulse_count <= 6'd5;
            r_cfg.pitch       <= 7'd72;
            r_cfg.velocity    <= 7'd127;
            r_cfg.channel     <= 5'd1;
            r_cfg.enable      <= 1'b0;
            r_cfg.mute        <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                ert_pkg::REG_STEP_COUNT:  r_cfg.step_count  <= pwdata[ert_pkg::STEPCFG_W-1:0];
                ert_pkg::REG_PULSE_COUNT: r_cfg.pulse_count <= pwdata[ert_pkg::STEPCFG_W-1:0];
                ert_pkg::REG_PITCH:       r_cfg.pitch       <= pwdata[ert_pkg::PITCH_W-1:0];
                ert_pkg::REG_VELOCITY:    r_cfg.velocity    <= pwdata[ert_pkg::VEL_W-1:0];
                ert_pkg::REG_CHANNEL:     r_cfg.channel     <= pwdata[ert_pkg::CHAN_W-1:0];
                ert_pkg::REG_ENABLE:      r_cfg.enable      <= pwdata[0];
                ert_pkg::REG_MUTE:        r_cfg.mute        <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            ert_pkg::REG_STEP_COUNT:  prdata = ert_pkg::DATA_W'(r_cfg.step_count);
            ert_pkg::REG_PULSE_COUNT: prdata = ert_pkg::DATA_W'(r_cfg.pulse_count);
            ert_pkg::REG_PITCH:       prdata = ert_pkg::DATA_W'(r_cfg.pitch);
            ert_pkg::REG_VELOCITY:    prdata = ert_pkg::DATA_W'(r_cfg.velocity);
            ert_pkg::REG_CHANNEL:     prdata = ert_pkg::DATA_W'(r_cfg.channel);
            ert_pkg::REG_ENABLE:      prdata = ert_pkg::DATA_W'(r_cfg.enable);
            ert_pkg::REG_MUTE:        prdata = ert_pkg::DATA_W'(r_cfg.mute);
            default:                  prdata = '0;
        endcase
    end

    ert_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    ert_dp #(
        .MAX_STEPS (MAX_STEPS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_beat_number   (i_beat_number),
        .i_cfg           (r_cfg),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_note_channel  (o_note_channel),
        .o_note_pitch    (o_note_pitch),
        .o_note_velocity (o_note_velocity),
        .o_step_index    (o_step_index)
    );

endmodule

`default_nettype wire

/* sim/ert_note_checker.sv */
module ert_note_checker
    import ert_pkg::*;
#(
    parameter int MAX_STEPS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                o_stall,
    input  logic [BEAT_W-1:0]   i_beat_number,
    input  logic                o_valid,
    input  logic                i_stall,
    input  logic [CHAN_W-1:0]   o_note_channel,
    input  logic [PITCH_W-1:0]  o_note_pitch,
    input  logic [VEL_W-1:0]    o_note_velocity,
    input  logic [IDXOUT_W-1:0] o_step_index,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                pready,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output int                  fail_count,
    output int                  notes_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CHAN_W-1:0]   channel;
        logic [PITCH_W-1:0]  pitch;
        logic [VEL_W-1:0]    velocity;
        logic [IDXOUT_W-1:0] step;
    } t_note;

    localparam t_cfg CFG_AT_RESET = '{
        step_count:  6'd13,
        pulse_count: 6'd5,
        pitch:       7'd72,
        velocity:    7'd127,
        channel:     5'd1,
        enable:      1'b0,
        mute:        1'b0
    };

    t_cfg             cfg = CFG_AT_RESET;
    logic [LAST_W-1:0] last_beat = '1;
    t_note            expected_notes[$];

    initial begin
        fail_count = 0;
        notes_pending = 0;
    end

    // Returns 1 when the beat is new, enabled and unmuted and lands on a pulse of the Euclidean pattern.
    function automatic logic predict_note(input logic [BEAT_W-1:0] beat, output t_note note);
        int unsigned steps;
        int unsigned pulses;
        int unsigned pos;
        logic [CHAN_W-1:0] chan;
        note = '0;
        if (!cfg.enable || cfg.mute)
            return 1'b0;
        if ({1'b0, beat} == last_beat)
            return 1'b0;
        last_beat = {1'b0, beat};
        steps = cfg.step_count;
        if (steps == 0)
            steps = 1;
        if (steps > MAX_STEPS)
            steps = MAX_STEPS;
        pulses = cfg.pulse_count;
        if (pulses > steps)
            pulses = steps;
        pos = beat % steps;
        if (pos != 0 && (pos * pulses) / steps == ((pos - 1) * pulses) / steps)
            return 1'b0;
        chan = cfg.channel;
        if (chan < CHAN_MIN)
            chan = CHAN_MIN;
        if (chan > CHAN_MAX)
            chan = CHAN_MAX;
        note.channel  = chan;
        note.pitch    = cfg.pitch;
        note.velocity = cfg.velocity;
        note.step     = pos[IDXOUT_W-1:0];
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : watch
        t_note got;
        t_note want;
        t_note fresh;
        if (!i_rst_n) begin
            cfg = CFG_AT_RESET;
            last_beat = '1;
            expected_notes.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[4:2]))
                    REG_STEP_COUNT:  cfg.step_count  = pwdata[STEPCFG_W-1:0];
                    REG_PULSE_COUNT: cfg.pulse_count = pwdata[STEPCFG_W-1:0];
                    REG_PITCH:       cfg.pitch       = pwdata[PITCH_W-1:0];
                    REG_VELOCITY:    cfg.velocity    = pwdata[VEL_W-1:0];
                    REG_CHANNEL:     cfg.channel     = pwdata[CHAN_W-1:0];
                    REG_ENABLE:      cfg.enable      = pwdata[0];
                    REG_MUTE:        cfg.mute        = pwdata[0];
                    default: ;
                endcase
            end

            // Outputs are matched first: a note leaving at this edge belongs to an older request.
            if (o_valid && !i_stall) begin
                got = '{o_note_channel, o_note_pitch, o_note_velocity, o_step_index};
                if (expected_notes.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: unexpected note: ch %0d pitch %0d vel %0d step %0d",
                                 $realtime, got.channel, got.pitch, got.velocity, got.step);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_notes.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10)
                            $display({"%0t: note mismatch: expected ch %0d pitch %0d vel %0d ",
                                      "step %0d, got ch %0d pitch %0d vel %0d step %0d"},
                                     $realtime, want.channel, want.pitch, want.velocity,
                                     want.step, got.channel, got.pitch, got.velocity, got.step);
                        fail_count <= fail_count + 1;
                    end
                end
            end

            if (i_valid && !o_stall) begin
                if (predict_note(i_beat_number, fresh))
                    expected_notes = {expected_notes, fresh};
            end
        end
        notes_pending <= expected_notes.size();
    end

endmodule

/* sim/tb_euclidean_rhythm_trigger.sv */
module tb_euclidean_rhythm_trigger;
    timeunit 1ns;
    timeprecision 1ps;

    import ert_pkg::*;

    localparam int MAX_STEPS     = 32;
    localparam int LIVE_TARGET   = 600;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 1_000_000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic [BEAT_W-1:0]   i_beat_number = '0;
    logic                i_stall = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;

    logic                o_stall;
    logic                o_valid;
    logic [CHAN_W-1:0]   o_note_channel;
    logic [PITCH_W-1:0]  o_note_pitch;
    logic [VEL_W-1:0]    o_note_velocity;
    logic [IDXOUT_W-1:0] o_step_index;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    int   fail_count;
    int   notes_pending;
    int   cycle_count = 0;
    int   stall_run = 0;
    int   hold_left = 0;
    logic rx_busy = 1'b0;
    logic hold_kick = 1'b0;
    logic calm = 1'b0;

    always #5 i_clk = ~i_clk;

    euclidean_rhythm_trigger #(
        .MAX_STEPS(MAX_STEPS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_beat_number(i_beat_number),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_note_channel(o_note_channel),
        .o_note_pitch(o_note_pitch),
        .o_note_velocity(o_note_velocity),
        .o_step_index(o_step_index),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    ert_note_checker #(
        .MAX_STEPS(MAX_STEPS)
    ) notes_check (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_beat_number(i_beat_number),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_note_channel(o_note_channel),
        .o_note_pitch(o_note_pitch),
        .o_note_velocity(o_note_velocity),
        .o_step_index(o_step_index),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .pready(pready),
        .paddr(paddr),
        .pwdata(pwdata),
        .fail_count(fail_count),
        .notes_pending(notes_pending)
    );

    // Mostly short spans, now and then a long one.
    function automatic int pick_span();
        int r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 4);
        if (r < 95)
            return $urandom_range(5, 12);
        return $urandom_range(30, 80);
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Long receiver hold-off, started on request from the stimulus.
    always @(posedge i_clk) begin
        if (hold_kick)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_busy <= 1'b0;
            stall_run <= 0;
        end else begin
            if (stall_run > 0) begin
                stall_run <= stall_run - 1;
            end else begin
                rx_busy <= !calm && ($urandom_range(0, 2) == 0);
                stall_run <= pick_span();
            end
            i_stall <= rx_busy || (hold_left != 0);
        end
    end

    task automatic write_reg(input t_reg_idx idx, input logic [DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_beat(input logic [BEAT_W-1:0] beat);
        int gap;
        gap = calm ? 0 : (($urandom_range(0, 1) == 0) ? 0 : pick_span());
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_beat_number <= beat;
        do @(posedge i_clk); while (o_stall);
    endtask

    // A beat that yields no note may still be in flight, so wait out the latency too.
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (notes_pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [BEAT_W-1:0] opening[11];
        logic [BEAT_W-1:0] cursor;
        logic              active;
        int                live_items;
        int                burst;
        int                r;

        opening = '{31'd0, 31'd0, 31'd1, 31'd2, 31'd3, 31'd12, 31'd13, 31'h7FFF_FFFF,
                    31'h7FFF_FFFF, 31'h5555_5555, 31'h2AAA_AAAA};
        live_items = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Disabled after reset: beats are ignored.
        send_beat(31'd0);
        send_beat(31'd5);
        settle();

        // Reset pattern, including a repeated beat and both ends of the beat range.
        write_reg(REG_ENABLE, 32'd1);
        foreach (opening[k])
            send_beat(opening[k]);
        settle();

        // Muted beats must leave the last beat untouched.
        write_reg(REG_MUTE, 32'd1);
        send_beat(31'd100);
        send_beat(31'd101);
        settle();
        write_reg(REG_MUTE, 32'd0);
        send_beat(31'd101);
        settle();

        // Zero step count, pulse count, channel, pitch and velocity.
        write_reg(REG_STEP_COUNT, 32'd0);
        write_reg(REG_PULSE_COUNT, 32'd0);
        write_reg(REG_CHANNEL, 32'd0);
        write_reg(REG_PITCH, 32'd0);
        write_reg(REG_VELOCITY, 32'd0);
        send_beat(31'd7);
        send_beat(31'd8);
        settle();

        // Step count, pulse count and channel above range: steps and pulses clamp to the maximum, channel to 16.
        write_reg(REG_STEP_COUNT, 32'd63);
        write_reg(REG_PULSE_COUNT, 32'd63);
        write_reg(REG_CHANNEL, 32'd31);
        write_reg(REG_PITCH, 32'd127);
        write_reg(REG_VELOCITY, 32'd127);
        send_beat(31'd31);
        send_beat(31'd32);
        send_beat(31'd33);
        settle();

        // No pulses: only the downbeat fires.
        write_reg(REG_STEP_COUNT, 32'd7);
        write_reg(REG_PULSE_COUNT, 32'd0);
        write_reg(REG_CHANNEL, 32'd16);
        send_beat(31'd14);
        send_beat(31'd15);
        send_beat(31'd20);
        settle();

        // Every step fires while the receiver holds off, so the block backs up.
        calm <= 1'b1;
        write_reg(REG_STEP_COUNT, 32'd8);
        write_reg(REG_PULSE_COUNT, 32'd8);
        hold_kick <= 1'b1;
        @(posedge i_clk);
        hold_kick <= 1'b0;
        for (int k = 0; k < 12; k++)
            send_beat(31'd1000 + k);
        settle();

        while (live_items < LIVE_TARGET) begin
            calm <= ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 9);
            write_reg(REG_STEP_COUNT, (r == 0) ? $urandom_range(33, 63) : (r == 1) ? 0 :
                      (r == 2) ? 32 : (r == 3) ? 1 : $urandom_range(2, 31));
            r = $urandom_range(0, 9);
            write_reg(REG_PULSE_COUNT, (r == 0) ? 0 : (r == 1) ? $urandom_range(33, 63) :
                      $urandom_range(1, 32));
            write_reg(REG_PITCH, $urandom_range(0, 127));
            write_reg(REG_VELOCITY, $urandom_range(0, 127));
            write_reg(REG_CHANNEL, $urandom_range(0, 31));
            active = ($urandom_range(0, 9) != 0);
            write_reg(REG_ENABLE, {31'd0, active});
            r = ($urandom_range(0, 9) == 0);
            write_reg(REG_MUTE, r);
            active = active && (r == 0);

            case ($urandom_range(0, 3))
                0: cursor = $urandom_range(0, 20);
                1: cursor = 31'h7FFF_FFFF - $urandom_range(0, 20);
                default: cursor = $urandom;
            endcase

            // A host counting up, with repeats, backward steps and random jumps mixed in.
            burst = active ? $urandom_range(30, 70) : 8;
            for (int k = 0; k < burst; k++) begin
                r = $urandom_range(0, 99);
                if (r < 14 && r >= 8)
                    cursor = $urandom;
                else if (r < 17 && r >= 14)
                    cursor = cursor - $urandom_range(1, 40);
                else if (r >= 17)
                    cursor = cursor + 1'b1;
                send_beat(cursor);
                if (active)
                    live_items++;
            end
            settle();
        end

        if (fail_count == 0 && notes_pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/ert_pkg.sv
design/ert_ctrl.sv
design/ert_dp.sv
design/euclidean_rhythm_trigger.sv
sim/ert_note_checker.sv
sim/tb_euclidean_rhythm_trigger.sv
